[rtl/isw_pkg.sv]
// ----------------------------------------------------------------------------
// isw_pkg
// Types and constants shared by the sensor word reader modules.
// ----------------------------------------------------------------------------
package isw_pkg;

    localparam int ADDR_W      = 7;
    localparam int CMD_W       = 8;
    localparam int RAW_W       = 15;
    localparam int CENTI_W     = 17;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;

    localparam logic [ADDR_W-1:0]  ADDR_RESET   = 7'h5B;
    // 27315 + 1: kelvin offset in hundredths plus the half-step correction
    localparam logic [CENTI_W-1:0] CENTI_OFFSET = 17'd27316;

    // byte slot within the write and read groups
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;

    // one bus tick as taken from the input channel
    typedef struct packed {
        logic             sda_in;
        logic [CMD_W-1:0] command;
        logic             start_request;
    } tick_t;

    // one result item
    typedef struct packed {
        logic signed [CENTI_W-1:0] centi_celsius;
        logic [RAW_W-1:0]          raw_word;
        logic                      nack_seen;
        logic                      done_res;
        logic                      busy_res;
        logic                      sda_out;
        logic                      scl_out;
    } result_t;

    typedef enum logic [17:0] {
        ST_IDLE     = 18'b000000000000000001,
        ST_START_A  = 18'b000000000000000010,
        ST_START_B  = 18'b000000000000000100,
        ST_TX_BITS  = 18'b000000000000001000,
        ST_TX_ACK_A = 18'b000000000000010000,
        ST_TX_ACK_B = 18'b000000000000100000,
        ST_TX_ACK_C = 18'b000000000001000000,
        ST_RS_A     = 18'b000000000010000000,
        ST_RS_B     = 18'b000000000100000000,
        ST_RS_C     = 18'b000000001000000000,
        ST_RS_D     = 18'b000000010000000000,
        ST_RX_BITS  = 18'b000000100000000000,
        ST_RX_ACK_A = 18'b000001000000000000,
        ST_RX_ACK_B = 18'b000010000000000000,
        ST_RX_ACK_C = 18'b000100000000000000,
        ST_STOP_A   = 18'b001000000000000000,
        ST_STOP_B   = 18'b010000000000000000
    } phase_t;

endpackage

[rtl/isw_front.sv]
// ----------------------------------------------------------------------------
// isw_front
// Input side: takes tick requests and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module isw_front import isw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  tick_t       in_tick,
    output logic        q_valid,
    input  logic        q_pop,
    output tick_t       q_tick
);

    tick_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_tick   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_tick;
        end
    end

endmodule

[rtl/isw_seq.sv]
// ----------------------------------------------------------------------------
// isw_seq
// Bus phase sequencer: runs one queued tick per cycle into the output register unless a held result stalls it.
// ----------------------------------------------------------------------------
module isw_seq import isw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic              q_valid,
    output logic              q_pop,
    input  tick_t             q_tick,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res
);

    phase_t            phase_reg, phase_next;
    logic [3:0]        bit_cnt_reg, bit_cnt_next;
    logic [7:0]        shift_reg, shift_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [7:0]        low_reg, low_next;
    logic [7:0]        high_reg, high_next;
    logic              nack_reg, nack_next;
    logic [1:0]        slot_reg, slot_next;
    logic [ADDR_W-1:0] addr_reg;
    logic              valid_reg;
    result_t           res_reg, res_next;
    logic              fire;
    logic              scl, sda, done;
    logic [RAW_W-1:0]  raw;

    assign q_pop     = q_valid && (!valid_reg || out_ready);
    assign fire      = q_pop;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign raw       = {high_reg[6:0], low_reg};

    always_comb begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        cmd_next     = cmd_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        nack_next    = nack_reg;
        slot_next    = slot_reg;
        scl          = 1'b1;
        sda          = 1'b1;
        done         = 1'b0;

        case (phase_reg)
            ST_IDLE: begin
                if (q_tick.start_request) begin
                    cmd_next     = q_tick.command;
                    nack_next    = 1'b0;
                    bit_cnt_next = 4'd0;
                    phase_next   = ST_START_A;
                end
            end
            ST_START_A: begin
                sda        = 1'b0;
                phase_next = ST_START_B;
            end
            ST_START_B: begin
                scl          = 1'b0;
                sda          = 1'b0;
                shift_next   = {addr_reg, 1'b0};
                bit_cnt_next = 4'd0;
                slot_next    = SLOT_0;
                phase_next   = ST_TX_BITS;
            end
            ST_TX_BITS: begin
                sda = shift_reg[7];
                scl = bit_cnt_reg[0];
                if (bit_cnt_reg[0]) begin
                    shift_next = {shift_reg[6:0], 1'b0};
                end
                if (bit_cnt_reg == 4'd15) begin
                    bit_cnt_next = 4'd0;
                    phase_next   = ST_TX_ACK_A;
                end else begin
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                end
            end
            ST_TX_ACK_A: begin
                scl        = 1'b0;
                phase_next = ST_TX_ACK_B;
            end
            ST_TX_ACK_B: begin
                nack_next  = nack_reg | q_tick.sda_in;
                phase_next = ST_TX_ACK_C;
            end
            ST_TX_ACK_C: begin
                scl = 1'b0;
                sda = 1'b0;
                case (slot_reg)
                    SLOT_0: begin
                        shift_next   = cmd_reg;
                        bit_cnt_next = 4'd0;
                        slot_next    = SLOT_1;
                        phase_next   = ST_TX_BITS;
                    end
                    SLOT_1: begin
                        phase_next = ST_RS_A;
                    end
                    default: begin
                        shift_next   = 8'd0;
                        bit_cnt_next = 4'd0;
                        slot_next    = SLOT_0;
                        phase_next   = ST_RX_BITS;
                    end
                endcase
            end
            ST_RS_A: begin
                scl        = 1'b0;
                phase_next = ST_RS_B;
            end
            ST_RS_B: begin
                phase_next = ST_RS_C;
            end
            ST_RS_C: begin
                sda        = 1'b0;
                phase_next = ST_RS_D;
            end
            ST_RS_D: begin
                scl          = 1'b0;
                sda          = 1'b0;
                shift_next   = {addr_reg, 1'b1};
                bit_cnt_next = 4'd0;
                slot_next    = SLOT_2;
                phase_next   = ST_TX_BITS;
            end
            ST_RX_BITS: begin
                scl = bit_cnt_reg[0];
                if (bit_cnt_reg[0]) begin
                    shift_next = {shift_reg[6:0], q_tick.sda_in};
                end
                if (bit_cnt_reg == 4'd15) begin
                    bit_cnt_next = 4'd0;
                    phase_next   = ST_RX_ACK_A;
                end else begin
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                end
            end
            ST_RX_ACK_A: begin
                scl = 1'b0;
                sda = (slot_reg == SLOT_2);
                if (slot_reg == SLOT_0) begin
                    low_next = shift_reg;
                end else if (slot_reg == SLOT_1) begin
                    high_next = shift_reg;
                end
                phase_next = ST_RX_ACK_B;
            end
            ST_RX_ACK_B: begin
                sda        = (slot_reg == SLOT_2);
                phase_next = ST_RX_ACK_C;
            end
            ST_RX_ACK_C: begin
                scl = 1'b0;
                sda = 1'b0;
                if (slot_reg == SLOT_2) begin
                    phase_next = ST_STOP_A;
                end else begin
                    shift_next   = 8'd0;
                    bit_cnt_next = 4'd0;
                    slot_next    = slot_reg + 2'd1;
                    phase_next   = ST_RX_BITS;
                end
            end
            ST_STOP_A: begin
                sda        = 1'b0;
                phase_next = ST_STOP_B;
            end
            ST_STOP_B: begin
                done       = 1'b1;
                phase_next = ST_IDLE;
            end
            default: begin
                phase_next   = ST_IDLE;
                bit_cnt_next = 4'd0;
            end
        endcase

        res_next.scl_out       = scl;
        res_next.sda_out       = sda;
        res_next.busy_res      = (phase_next != ST_IDLE);
        res_next.done_res      = done;
        res_next.nack_seen     = nack_next;
        res_next.raw_word      = done ? raw : '0;
        res_next.centi_celsius = done ? $signed({1'b0, raw, 1'b0} - CENTI_OFFSET) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= ST_IDLE;
            bit_cnt_reg <= 4'd0;
            shift_reg   <= 8'd0;
            cmd_reg     <= '0;
            low_reg     <= 8'd0;
            high_reg    <= 8'd0;
            nack_reg    <= 1'b0;
            slot_reg    <= SLOT_0;
            addr_reg    <= ADDR_RESET;
            valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                addr_reg <= cfg_addr;
            end
            if (fire) begin
                phase_reg   <= phase_next;
                bit_cnt_reg <= bit_cnt_next;
                shift_reg   <= shift_next;
                cmd_reg     <= cmd_next;
                low_reg     <= low_next;
                high_reg    <= high_next;
                nack_reg    <= nack_next;
                slot_reg    <= slot_next;
                valid_reg   <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

endmodule

[rtl/i2c_sensor_word_reader.sv]
// ----------------------------------------------------------------------------
// i2c_sensor_word_reader
// I2C master running one read-word transaction, one bus phase per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Every request on the s_ channel is one bus tick: start_request, command
//   and the sampled SDA level. Every tick gives exactly one result on the m_
//   channel with the SCL/SDA levels to drive, busy, done, the sticky NACK flag
//   and, on the done tick, the raw word and temperature in 0.01 degC.
//   cfg_valid/cfg_data write the 7-bit slave address; write it only while idle.
// Throughput: one tick per clock cycle, sustained while m_tready is high, through the sequencer.
// Path: an accepted s_ tick is written to a queue entry, then to the output
//   register, which raises m_tvalid.
// Reset (aresetn low, synchronous): queue empty, sequencer idle, address 0x5B.
// Stall: while m_tready is low the result holds; the two-entry queue keeps
//   taking ticks until full, then s_tready drops.
// ----------------------------------------------------------------------------
module i2c_sensor_word_reader import isw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // start_request[0], command[8:1], sda_in[9], zero pad [15:10]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], nack_seen[4],
    // raw_word[19:5], centi_celsius[36:20], zero pad [39:37]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready
);

    tick_t   in_tick;
    tick_t   q_tick;
    logic    q_valid;
    logic    q_pop;
    result_t res;

    assign in_tick.start_request = s_tdata[0];
    assign in_tick.command       = s_tdata[8:1];
    assign in_tick.sda_in        = s_tdata[9];
    assign cfg_ready             = 1'b1;
    assign m_tdata               = {3'b000, res};

    isw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_tick  (in_tick),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_tick   (q_tick)
    );

    isw_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_addr  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_tick    (q_tick),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

endmodule

[rtl/isw_checker.sv]
// ----------------------------------------------------------------------------
// isw_checker
// Port-level checks on the result stream of the sensor word reader.
// ----------------------------------------------------------------------------
module isw_checker import isw_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready
);

    // done marks the stop tick: bus released, transaction over
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2] && m_tdata[0] && m_tdata[1])
        else $error("done result with bus not idle");

    a_quiet_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[36:5] == 32'd0)
        else $error("word fields nonzero outside done");

    a_centi_math: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |->
            m_tdata[36:20] == 17'({1'b0, m_tdata[19:5], 1'b0} - CENTI_OFFSET))
        else $error("temperature does not match raw word");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind i2c_sensor_word_reader isw_checker u_isw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for i2c_sensor_word_reader: plays the slave side of
// whole read-word transactions tick by tick, predicts every bus result and
// checks it field by field under random stalls on both channels.
// ----------------------------------------------------------------------------

import isw_pkg::*;

// Tracks the master's bus sequencer and holds the bus levels it must produce.
class word_read_checker;

    localparam int MAX_REPORTED = 10;

    phase_t             phase;
    logic [1:0]         slot;
    logic [3:0]         bit_cnt;
    logic [7:0]         shift_byte;
    logic [7:0]         cmd_latch;
    logic [7:0]         low_byte;
    logic [7:0]         high_byte;
    logic               nack;
    logic [ADDR_W-1:0]  address;
    result_t            expected_bus_q[$];
    int                 errors;
    int                 results_seen;

    function new();
        phase      = ST_IDLE;
        slot       = SLOT_0;
        bit_cnt    = '0;
        shift_byte = '0;
        cmd_latch  = '0;
        low_byte   = '0;
        high_byte  = '0;
        nack       = 1'b0;
        address    = ADDR_RESET;
        errors     = 0;
        results_seen = 0;
    endfunction

    function void set_address(logic [ADDR_W-1:0] a);
        address = a;
    endfunction

    function int pending();
        return expected_bus_q.size();
    endfunction

    // Advance the sequencer by one bus tick and queue the levels it drives.
    function void predict_tick(logic [S_TDATA_W-1:0] data);
        tick_t              t;
        result_t            r;
        logic               half;
        logic [RAW_W-1:0]   raw;
        t = tick_t'(data[$bits(tick_t)-1:0]);
        r = '0;
        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        half = bit_cnt[0];
        case (phase)
            ST_IDLE: begin
                if (t.start_request) begin
                    cmd_latch = t.command;
                    nack      = 1'b0;
                    bit_cnt   = '0;
                    phase     = ST_START_A;
                end
            end
            ST_START_A: begin
                r.sda_out = 1'b0;
                phase = ST_START_B;
            end
            ST_START_B: begin
                r.scl_out  = 1'b0;
                r.sda_out  = 1'b0;
                shift_byte = {address, 1'b0};
                bit_cnt    = '0;
                slot       = SLOT_0;
                phase      = ST_TX_BITS;
            end
            ST_TX_BITS: begin
                r.sda_out = shift_byte[7];
                r.scl_out = half;
                if (half)
                    shift_byte = shift_byte << 1;
                if (bit_cnt == 4'd15) begin
                    bit_cnt = '0;
                    phase = ST_TX_ACK_A;
                end else begin
                    bit_cnt = bit_cnt + 4'd1;
                end
            end
            ST_TX_ACK_A: begin
                r.scl_out = 1'b0;
                phase = ST_TX_ACK_B;
            end
            ST_TX_ACK_B: begin
                nack  = nack | t.sda_in;
                phase = ST_TX_ACK_C;
            end
            ST_TX_ACK_C: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                if (slot == SLOT_0) begin
                    shift_byte = cmd_latch;
                    bit_cnt    = '0;
                    slot       = SLOT_1;
                    phase      = ST_TX_BITS;
                end else if (slot == SLOT_1) begin
                    phase = ST_RS_A;
                end else begin
                    shift_byte = '0;
                    bit_cnt    = '0;
                    slot       = SLOT_0;
                    phase      = ST_RX_BITS;
                end
            end
            ST_RS_A: begin
                r.scl_out = 1'b0;
                phase = ST_RS_B;
            end
            ST_RS_B: phase = ST_RS_C;
            ST_RS_C: begin
                r.sda_out = 1'b0;
                phase = ST_RS_D;
            end
            ST_RS_D: begin
                r.scl_out  = 1'b0;
                r.sda_out  = 1'b0;
                shift_byte = {address, 1'b1};
                bit_cnt    = '0;
                slot       = SLOT_2;
                phase      = ST_TX_BITS;
            end
            ST_RX_BITS: begin
                r.scl_out = half;
                if (half)
                    shift_byte = {shift_byte[6:0], t.sda_in};
                if (bit_cnt == 4'd15) begin
                    bit_cnt = '0;
                    phase = ST_RX_ACK_A;
                end else begin
                    bit_cnt = bit_cnt + 4'd1;
                end
            end
            ST_RX_ACK_A: begin
                if (slot == SLOT_0)
                    low_byte = shift_byte;
                else if (slot == SLOT_1)
                    high_byte = shift_byte;
                r.scl_out = 1'b0;
                r.sda_out = (slot == SLOT_2);   // NAK only on the third byte
                phase = ST_RX_ACK_B;
            end
            ST_RX_ACK_B: begin
                r.sda_out = (slot == SLOT_2);
                phase = ST_RX_ACK_C;
            end
            ST_RX_ACK_C: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                if (slot == SLOT_2) begin
                    phase = ST_STOP_A;
                end else begin
                    shift_byte = '0;
                    bit_cnt    = '0;
                    slot       = slot + 2'd1;
                    phase      = ST_RX_BITS;
                end
            end
            ST_STOP_A: begin
                r.sda_out = 1'b0;
                phase = ST_STOP_B;
            end
            ST_STOP_B: begin
                raw = {high_byte[6:0], low_byte};
                r.done_res      = 1'b1;
                r.raw_word      = raw;
                r.centi_celsius = {1'b0, raw, 1'b0} - CENTI_OFFSET;
                phase = ST_IDLE;
            end
            default: begin
                phase   = ST_IDLE;
                bit_cnt = '0;
            end
        endcase
        r.busy_res  = (phase != ST_IDLE);
        r.nack_seen = nack;
        expected_bus_q.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTED)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
        end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data);
        result_t got;
        result_t want;
        got = result_t'(data[$bits(result_t)-1:0]);
        results_seen++;
        if (expected_bus_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTED)
                $display("result %0d: unexpected, data 0x%0h", results_seen, data);
            return;
        end
        want = expected_bus_q.pop_front();
        compare("scl_out",       {31'b0, want.scl_out},   {31'b0, got.scl_out});
        compare("sda_out",       {31'b0, want.sda_out},   {31'b0, got.sda_out});
        compare("busy_res",      {31'b0, want.busy_res},  {31'b0, got.busy_res});
        compare("done_res",      {31'b0, want.done_res},  {31'b0, got.done_res});
        compare("nack_seen",     {31'b0, want.nack_seen}, {31'b0, got.nack_seen});
        compare("raw_word",      {17'b0, want.raw_word},  {17'b0, got.raw_word});
        compare("centi_celsius", {15'b0, want.centi_celsius},
                                 {15'b0, got.centi_celsius});
    endfunction
endclass

module tb;
    import isw_pkg::*;

    // one full read-word transaction, counted from the request tick
    localparam int TXN_TICKS     = 123;
    localparam int TX_ACK0_TICK  = 20;   // SCL-high tick of the first ACK slot
    localparam int RX0_TICK      = 64;   // first tick of the low byte bits
    localparam int GROUP_TICKS   = 19;   // eight bits plus the ACK slot
    localparam int RS_TICKS      = 4;
    localparam int HOLD_CYCLES   = 64;
    localparam int END_CYCLES    = 8;
    localparam int STALL_LIMIT   = 1000;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [ADDR_W-1:0]    cfg_data  = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    word_read_checker sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    int  quiet_cycles;

    i2c_sensor_word_reader dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random back-pressure, plus one long hold on demand
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // handshake monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.predict_tick(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (cfg_valid && cfg_ready)
                sb.set_address(cfg_data);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** i2c_sensor_word_reader: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_tick(input tick_t t);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - $bits(tick_t)){1'b0}}, t};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering requests until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic idle_ticks(input int n);
        tick_t t;
        for (int i = 0; i < n; i++) begin
            t.start_request = 1'b0;
            t.command       = 8'($urandom);
            t.sda_in        = 1'($urandom_range(0, 1));
            send_tick(t);
        end
    endtask

    // One read-word transaction as seen from the slave. rd_data holds the three
    // bytes read, first byte lowest; nack_mask leaves SDA high in ACK slots.
    task automatic run_read(input logic [7:0] cmd, input logic [23:0] rd_data,
                            input logic [2:0] nack_mask, input bit noisy,
                            input int pause_at);
        tick_t t;
        int    rx_at;
        int    ack_at;
        int    off;
        for (int i = 0; i < TXN_TICKS; i++) begin
            // requests while busy must be ignored
            t.start_request = (i == 0) ? 1'b1 : (noisy && $urandom_range(0, 3) == 0);
            t.command       = (i == 0) ? cmd : 8'($urandom);
            t.sda_in        = 1'($urandom_range(0, 1));
            for (int b = 0; b < 3; b++) begin
                ack_at = TX_ACK0_TICK + GROUP_TICKS * b + ((b == 2) ? RS_TICKS : 0);
                rx_at  = RX0_TICK + GROUP_TICKS * b;
                off    = i - rx_at;
                if (i == ack_at)
                    t.sda_in = nack_mask[b];
                if (off >= 0 && off < 16 && off[0])
                    t.sda_in = rd_data[8 * b + 7 - off / 2];
            end
            if (i == pause_at)
                drain();
            send_tick(t);
        end
    endtask

    task automatic random_read(input int pause_at);
        logic [23:0] rd;
        logic [2:0]  nk;
        case ($urandom_range(0, 7))
            0:       rd = '0;
            1:       rd = '1;
            default: rd = 24'($urandom);
        endcase
        nk = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'b000;
        idle_ticks($urandom_range(0, 4));
        run_read(8'($urandom), rd, nk, 1'($urandom_range(0, 1)), pause_at);
    endtask

    task automatic write_address(input logic [ADDR_W-1:0] a);
        drain();
        cfg_data  <= a;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        hold_request  = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 19;
        recv_idle_pct = 80;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle noise, then extreme commands, data and NACKs
        idle_ticks(4);
        run_read(8'h00, 24'h000000, 3'b000, 1'b0, -1);
        run_read(8'hFF, 24'hFFFFFF, 3'b111, 1'b1, -1);
        run_read(8'hA5, 24'h00805A, 3'b010, 1'b1, -1);

        write_address('0);
        send_idle_pct = 80;
        recv_idle_pct = 19;
        random_read(-1);
        random_read(-1);

        write_address('1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold while the sender keeps offering
        hold_request = 1'b1;
        random_read(-1);
        random_read($urandom_range(1, TXN_TICKS - 2));

        write_address(ADDR_W'($urandom));
        random_read(-1);
        idle_ticks(3);

        drain();
        repeat (END_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** i2c_sensor_word_reader: PASSED **");
        else
            $display("** i2c_sensor_word_reader: FAILED **");
        $finish;
    end
endmodule
